// File: rtl/sat_pkg.sv
// Shared types and constants for the signal alarm table.
// No dependencies; imported by every other file except sat_ram.
package sat_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 22;
    localparam int SIG_W       = 7;
    localparam int DELAY_W     = 16;
    localparam int SEC_W       = 32;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_REQ    = 2'd1,
        CMD_CANCEL = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_QUEUED    = 3'd1,
        KIND_REFUSED   = 3'd2,
        KIND_CANCELLED = 3'd3,
        KIND_NOTFOUND  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRE,
        S_FLUSH,
        S_PACK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              thr;
        logic [ID_W-1:0]   id;
        logic [SIG_W-1:0]  sig;
        logic [SEC_W-1:0]  deadline;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_kind             kind;
        logic              thr;
        logic [ID_W-1:0]   id;
        logic [SIG_W-1:0]  sig;
        logic              last;
    } t_result;

    // controller -> result stage
    typedef struct packed {
        logic  fire;   // a due entry is on the read data
        logic  flush;  // release the held fired entry as last of run
        logic  resp;   // single response for request or cancel
        t_kind kind;
    } t_emit_ctl;

    // result stage -> controller
    typedef struct packed {
        logic free;    // output register can take a new result
        logic pend;    // a fired entry is held back
    } t_emit_sts;

endpackage

// File: rtl/sat_req_if.sv
// Request channel of the alarm table: command and alarm fields.
// Depends on sat_pkg.
interface sat_req_if;
    import sat_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic                owner_is_thread;
    logic [ID_W-1:0]     owner_id;
    logic [SIG_W-1:0]    signal_number;
    logic [DELAY_W-1:0]  delay_seconds;

    modport source (output valid, cmd, owner_is_thread, owner_id, signal_number,
                    delay_seconds, input ready);
    modport sink   (input valid, cmd, owner_is_thread, owner_id, signal_number,
                    delay_seconds, output ready);
endinterface

// File: rtl/sat_res_if.sv
// Result channel of the alarm table.
// Depends on sat_pkg.
interface sat_res_if;
    import sat_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        result_kind;
    logic              target_is_thread;
    logic [ID_W-1:0]   target_id;
    logic [SIG_W-1:0]  fired_signal;
    logic              last_of_run;

    modport source (output valid, result_kind, target_is_thread, target_id,
                    fired_signal, last_of_run, input ready);
    modport sink   (input valid, result_kind, target_is_thread, target_id,
                    fired_signal, last_of_run, output ready);
endinterface

// File: rtl/sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sat_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sat_emit.sv
// Result stage: holds back one fired entry (so the last of a run can be
// marked) and owns the output register. Depends on sat_pkg, sat_res_if.
module sat_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sat_pkg::t_emit_ctl i_ctl,
    input  sat_pkg::t_entry    i_ent,
    output sat_pkg::t_emit_sts o_sts,
    sat_res_if.source          o_res
);
    import sat_pkg::*;

    logic    r_pv, n_pv;
    logic    r_ov, n_ov;
    t_entry  r_pend, n_pend;
    t_result r_out, n_out;
    logic    free;

    assign free = !r_ov || o_res.ready;

    always_comb begin
        n_pv   = r_pv;
        n_ov   = r_ov && !o_res.ready;
        n_pend = r_pend;
        n_out  = r_out;
        if (i_ctl.fire) begin
            if (r_pv) begin
                n_ov  = 1'b1;
                n_out = '{kind: KIND_FIRED, thr: r_pend.thr, id: r_pend.id,
                          sig: r_pend.sig, last: 1'b0};
            end
            n_pv   = 1'b1;
            n_pend = i_ent;
        end else if (i_ctl.flush) begin
            n_pv  = 1'b0;
            n_ov  = 1'b1;
            n_out = '{kind: KIND_FIRED, thr: r_pend.thr, id: r_pend.id,
                      sig: r_pend.sig, last: 1'b1};
        end else if (i_ctl.resp) begin
            n_ov  = 1'b1;
            n_out = '{kind: i_ctl.kind, thr: 1'b0, id: '0, sig: '0, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_pv <= n_pv;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_sts.free             = free;
    assign o_sts.pend             = r_pv;
    assign o_res.valid            = r_ov;
    assign o_res.result_kind      = r_out.kind;
    assign o_res.target_is_thread = r_out.thr;
    assign o_res.target_id        = r_out.id;
    assign o_res.fired_signal     = r_out.sig;
    assign o_res.last_of_run      = r_out.last;
endmodule

// File: rtl/signal_alarm_table_unit.sv
// Signal alarm table: an ordered list of up to TABLE_DEPTH pending alarms
// (owner, signal, deadline in seconds) kept oldest first in one RAM with a
// registered read. A request transfer appends an alarm due at now + delay
// (or is refused when full) and gives one result; a cancel removes the
// oldest alarm of that owner and gives one result; a tick adds one second,
// fires every due alarm newest first (wrap-safe signed compare) and gives
// one result per fired alarm, none if nothing is due. cmd 3 is ignored.
// One item is worked at a time; the request channel is ready only when the
// controller is idle, but it stays ready while a finished result waits in
// the output register. A tick makes a downward firing pass and, when an
// alarm fired, then an upward compaction pass; a cancel makes only the
// upward pass. Both passes walk the RAM one entry per cycle through its
// single read port, unless the firing pass stalls on output back-pressure.
module signal_alarm_table_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sat_req_if.sink   i_req,
    sat_res_if.source o_res
);
    import sat_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SEC_W-1:0]      r_sec, n_sec;
    logic [IDX_W-1:0]      r_ia, n_ia;      // next address to read
    logic [CNT_W-1:0]      r_left, n_left;  // reads still to issue
    logic                  r_dv, n_dv;      // read data stage valid
    logic [IDX_W-1:0]      r_di, n_di;      // index of read data
    logic [CNT_W-1:0]      r_wp, n_wp;      // compaction write pointer
    logic                  r_found, n_found;
    logic                  r_tick, n_tick;  // compaction drops due entries
    t_kind                 r_kind, n_kind;
    logic                  r_key_thr;
    logic [ID_W-1:0]       r_key_id;

    logic                  acc;
    logic                  full;
    logic [CNT_W-1:0]      cnt_m1;
    logic [SEC_W-1:0]      diff;
    logic                  due;
    logic                  match;
    logic                  drop;
    logic                  stall;
    logic                  issue;
    logic                  drained;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    t_entry                rd_ent;

    t_emit_ctl             emit_ctl;
    t_emit_sts             emit_sts;

    // ---------------------------------------------------------------
    // Table storage
    // ---------------------------------------------------------------
    sat_ram #(.W(ENTRY_W), .D(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_ia),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);

    // ---------------------------------------------------------------
    // Decode of read data
    // ---------------------------------------------------------------
    assign acc     = i_req.valid && i_req.ready;
    assign full    = (r_cnt == CNT_W'(TABLE_DEPTH));
    assign cnt_m1  = r_cnt - 1'b1;
    assign diff    = r_sec - rd_ent.deadline;
    assign due     = !diff[SEC_W-1];
    assign match   = (rd_ent.thr == r_key_thr) && (rd_ent.id == r_key_id);
    assign drop    = r_tick ? due : (!r_found && match);
    // firing a second due entry needs the output register free
    assign stall   = (r_state == S_FIRE) && r_dv && due && emit_sts.pend
                     && !emit_sts.free;
    assign issue   = (((r_state == S_FIRE) && !stall) || (r_state == S_PACK))
                     && (r_left != '0);
    assign drained = (r_left == '0) && !r_dv;

    assign i_req.ready = (r_state == S_IDLE);

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_req.cmd)
                        CMD_TICK:   n_state = S_FIRE;
                        CMD_REQ:    n_state = S_RESP;
                        CMD_CANCEL: n_state = S_PACK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_FIRE: begin
                if (drained) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (!emit_sts.pend)     n_state = S_IDLE;  // nothing fired
                else if (emit_sts.free) n_state = S_PACK;
            end
            S_PACK: begin
                if (drained) n_state = r_tick ? S_IDLE : S_RESP;
            end
            S_RESP: begin
                if (emit_sts.free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath and RAM control
    // ---------------------------------------------------------------
    always_comb begin
        n_cnt     = r_cnt;
        n_sec     = r_sec;
        n_ia      = r_ia;
        n_left    = r_left;
        n_dv      = r_dv;
        n_di      = r_di;
        n_wp      = r_wp;
        n_found   = r_found;
        n_tick    = r_tick;
        n_kind    = r_kind;
        ram_we    = 1'b0;
        ram_waddr = r_wp[IDX_W-1:0];
        ram_wdata = rd_ent;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_dv = 1'b0;
                    case (i_req.cmd)
                        CMD_TICK: begin
                            n_sec  = r_sec + 1'b1;
                            n_ia   = cnt_m1[IDX_W-1:0];
                            n_left = r_cnt;
                            n_tick = 1'b1;
                        end
                        CMD_REQ: begin
                            if (full) begin
                                n_kind = KIND_REFUSED;
                            end else begin
                                n_kind    = KIND_QUEUED;
                                n_cnt     = r_cnt + 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[IDX_W-1:0];
                                ram_wdata = '{thr: i_req.owner_is_thread,
                                              id: i_req.owner_id,
                                              sig: i_req.signal_number,
                                              deadline: r_sec + SEC_W'(i_req.delay_seconds)};
                            end
                        end
                        CMD_CANCEL: begin
                            n_ia    = '0;
                            n_left  = r_cnt;
                            n_wp    = '0;
                            n_found = 1'b0;
                            n_tick  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_FIRE: begin
                // downward walk, newest first; holds while stalled
                if (!stall) begin
                    if (issue) begin
                        n_ia   = r_ia - 1'b1;
                        n_left = r_left - 1'b1;
                        n_di   = r_ia;
                    end
                    n_dv = issue;
                end
            end
            S_FLUSH: begin
                if (emit_sts.pend && emit_sts.free) begin
                    n_ia    = '0;
                    n_left  = r_cnt;
                    n_wp    = '0;
                    n_found = 1'b0;
                    n_dv    = 1'b0;
                end
            end
            S_PACK: begin
                // upward walk: kept entries are copied down to r_wp, which
                // never passes the read address, so no forwarding is needed
                if (issue) begin
                    n_ia   = r_ia + 1'b1;
                    n_left = r_left - 1'b1;
                    n_di   = r_ia;
                end
                n_dv = issue;
                if (r_dv) begin
                    if (drop) begin
                        n_found = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                        n_wp   = r_wp + 1'b1;
                    end
                end
                if (drained) begin
                    n_cnt  = r_wp;
                    n_kind = r_found ? KIND_CANCELLED : KIND_NOTFOUND;
                end
            end
            S_RESP: ;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Result stage
    // ---------------------------------------------------------------
    always_comb begin
        emit_ctl.fire  = (r_state == S_FIRE) && r_dv && due && !stall;
        emit_ctl.flush = (r_state == S_FLUSH) && emit_sts.pend && emit_sts.free;
        emit_ctl.resp  = (r_state == S_RESP) && emit_sts.free;
        emit_ctl.kind  = r_kind;
    end

    sat_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (emit_ctl),
        .i_ent   (rd_ent),
        .o_sts   (emit_sts),
        .o_res   (o_res)
    );

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sec   <= '0;
            r_left  <= '0;
            r_dv    <= 1'b0;
            r_found <= 1'b0;
            r_tick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sec   <= n_sec;
            r_left  <= n_left;
            r_dv    <= n_dv;
            r_found <= n_found;
            r_tick  <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ia   <= n_ia;
        r_di   <= n_di;
        r_wp   <= n_wp;
        r_kind <= n_kind;
        if (acc) begin
            r_key_thr <= i_req.owner_is_thread;
            r_key_id  <= i_req.owner_id;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_pack_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PACK) && r_dv |-> (r_wp <= CNT_W'(r_di)))
        else $error("compaction write overtook read");

    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_ctl.fire && emit_sts.pend |-> emit_sts.free)
        else $error("fired entry pushed into busy output");

    a_req_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_req.cmd == CMD_REQ) && !full |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("request did not grow the table");
endmodule

// File: tb/tb_signal_alarm_table_unit.sv
// Self-checking testbench for signal_alarm_table_unit: request, cancel and tick
// transfers are checked result by result against an in-bench alarm table.
// Depends on sat_pkg, sat_req_if, sat_res_if and the unit itself.
module tb_signal_alarm_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sat_pkg::*;

    // cmd 3 is not a command; the unit must drop it without a result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int N_RANDOM     = 270;
    localparam int OWNERS       = 6;
    localparam int HOLD_OFF     = 400;             // long receiver stall, in cycles
    localparam int HOLD_AT      = 60;              // transfers before the stall starts
    localparam int STEADY_FROM  = 150;             // window with no idling on either side
    localparam int STEADY_TO    = 200;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 40;
    localparam int GAP_PCT      = 19;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               thr;
        logic [ID_W-1:0]    id;
        logic [SIG_W-1:0]   sig;
        logic [DELAY_W-1:0] delay;
    } t_alarm_cmd;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;

    // Bench-side copies of the channel signals: known from time zero, one writer each
    logic       req_valid = 1'b0;
    t_alarm_cmd req_item  = '0;
    logic       res_ready = 1'b0;
    logic       req_hs    = 1'b0;   // a request transfer happened at the last rising edge
    logic       rx_hold   = 1'b0;   // forced receiver stall
    int         accepted_cnt = 0;
    int         mismatch_cnt = 0;
    logic       steady;

    sat_req_if req_if ();
    sat_res_if res_if ();

    assign req_if.valid           = req_valid;
    assign req_if.cmd             = req_item.cmd;
    assign req_if.owner_is_thread = req_item.thr;
    assign req_if.owner_id        = req_item.id;
    assign req_if.signal_number   = req_item.sig;
    assign req_if.delay_seconds   = req_item.delay;
    assign res_if.ready           = res_ready;

    assign steady = (accepted_cnt >= STEADY_FROM) && (accepted_cnt < STEADY_TO);

    signal_alarm_table_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Alarm table mirror: oldest entry at index 0, newest at alarm_cnt-1.
    // Updated at each request transfer; results it predicts are queued in
    // order of arrival at the result port.
    // ------------------------------------------------------------------
    t_entry            alarm_tbl [TABLE_DEPTH];
    int                alarm_cnt = 0;
    logic [SEC_W-1:0]  now_secs  = '0;
    t_result           alarm_outcomes_q [$];
    t_alarm_cmd        alarm_cmds_q [$];

    // close the gap left by a removed alarm, keeping age order
    task automatic drop_alarm(input int pos);
        for (int j = pos; j + 1 < alarm_cnt; j++)
            alarm_tbl[j] = alarm_tbl[j + 1];
        alarm_cnt--;
    endtask

    task automatic apply_alarm_cmd(input t_alarm_cmd c);
        t_result          res;
        t_result          held;
        logic             have_held;
        logic [SEC_W-1:0] diff;
        int               i;
        logic             hit;
        res       = '0;
        held      = '0;
        have_held = 1'b0;
        hit       = 1'b0;
        case (c.cmd)
            CMD_TICK: begin
                now_secs = now_secs + 1'b1;
                // walk newest to oldest; hold each fired alarm back one step
                // so that the final one of the run can carry last_of_run
                i = alarm_cnt;
                while (i > 0) begin
                    i--;
                    diff = now_secs - alarm_tbl[i].deadline;
                    if (!diff[SEC_W-1]) begin
                        if (have_held)
                            alarm_outcomes_q.push_back(held);
                        held.kind = KIND_FIRED;
                        held.thr  = alarm_tbl[i].thr;
                        held.id   = alarm_tbl[i].id;
                        held.sig  = alarm_tbl[i].sig;
                        held.last = 1'b0;
                        have_held = 1'b1;
                        drop_alarm(i);
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    alarm_outcomes_q.push_back(held);
                end
            end
            CMD_REQ: begin
                res.last = 1'b1;
                if (alarm_cnt >= TABLE_DEPTH) begin
                    res.kind = KIND_REFUSED;
                end else begin
                    alarm_tbl[alarm_cnt].thr      = c.thr;
                    alarm_tbl[alarm_cnt].id       = c.id;
                    alarm_tbl[alarm_cnt].sig      = c.sig;
                    alarm_tbl[alarm_cnt].deadline = now_secs + SEC_W'(c.delay);
                    alarm_cnt++;
                    res.kind = KIND_QUEUED;
                end
                alarm_outcomes_q.push_back(res);
            end
            CMD_CANCEL: begin
                res.last = 1'b1;
                // only the oldest alarm of this exact owner goes
                for (i = 0; i < alarm_cnt && !hit; i++) begin
                    if (alarm_tbl[i].thr == c.thr && alarm_tbl[i].id == c.id) begin
                        drop_alarm(i);
                        hit = 1'b1;
                    end
                end
                res.kind = hit ? KIND_CANCELLED : KIND_NOTFOUND;
                alarm_outcomes_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [1:0] c, input logic thr,
                             input logic [ID_W-1:0] id, input logic [SIG_W-1:0] sig,
                             input logic [DELAY_W-1:0] dly);
        t_alarm_cmd item;
        item.cmd   = c;
        item.thr   = thr;
        item.id    = id;
        item.sig   = sig;
        item.delay = dly;
        alarm_cmds_q.push_back(item);
    endtask

    function automatic logic [ID_W-1:0] rand_id();
        logic [31:0] w;
        w = $urandom();
        return w[ID_W-1:0];
    endfunction

    function automatic logic [SIG_W-1:0] rand_sig();
        logic [31:0] w;
        w = $urandom();
        return w[SIG_W-1:0];
    endfunction

    function automatic logic [DELAY_W-1:0] rand_delay();
        logic [31:0] w;
        w = $urandom();
        return w[DELAY_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge, holds an item until its
    // transfer, pops it the falling edge after. Gaps only between items.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (req_hs)
            void'(alarm_cmds_q.pop_front());
        if (req_valid && !req_hs) begin
            // still waiting for the transfer: hold everything
        end else if (rst_n && alarm_cmds_q.size() > 0 &&
                     (steady || $urandom_range(99) >= GAP_PCT)) begin
            req_valid <= 1'b1;
            req_item  <= alarm_cmds_q[0];
        end else begin
            req_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, none in the steady window, and a long
    // forced stall so the unit backs up onto its request channel
    always @(negedge clk) begin
        res_ready <= rst_n && !rx_hold && (steady || $urandom_range(99) >= GAP_PCT);
    end

    initial begin
        wait (accepted_cnt >= HOLD_AT);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: result transfers are checked before this edge's request
    // transfer is predicted, so ordering within the edge cannot matter.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_result    want;
        t_alarm_cmd took;
        if (res_if.valid && res_if.ready) begin
            if (alarm_outcomes_q.size() == 0) begin
                $error("result with nothing pending: result_kind %0d", res_if.result_kind);
                mismatch_cnt++;
            end else begin
                want = alarm_outcomes_q.pop_front();
                if (res_if.result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind,
                           res_if.result_kind);
                    mismatch_cnt++;
                end
                if (res_if.target_is_thread !== want.thr) begin
                    $error("target_is_thread: expected %0d, got %0d", want.thr,
                           res_if.target_is_thread);
                    mismatch_cnt++;
                end
                if (res_if.target_id !== want.id) begin
                    $error("target_id: expected 0x%0h, got 0x%0h", want.id,
                           res_if.target_id);
                    mismatch_cnt++;
                end
                if (res_if.fired_signal !== want.sig) begin
                    $error("fired_signal: expected %0d, got %0d", want.sig,
                           res_if.fired_signal);
                    mismatch_cnt++;
                end
                if (res_if.last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last,
                           res_if.last_of_run);
                    mismatch_cnt++;
                end
            end
        end
        if (req_if.valid && req_if.ready) begin
            took.cmd   = req_if.cmd;
            took.thr   = req_if.owner_is_thread;
            took.id    = req_if.owner_id;
            took.sig   = req_if.signal_number;
            took.delay = req_if.delay_seconds;
            apply_alarm_cmd(took);
            accepted_cnt <= accepted_cnt + 1;
            req_hs       <= 1'b1;
        end else begin
            req_hs <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic              pool_thr [OWNERS];
        logic [ID_W-1:0]   pool_id  [OWNERS];
        int                random_items;
        int                r;
        int                n;
        int                sel;
        logic [DELAY_W-1:0] dly;

        random_items = 0;
        // small owner pool so cancels hit; first two share an id, differ in kind
        for (int k = 0; k < OWNERS; k++) begin
            pool_thr[k] = k[0];
            pool_id[k]  = rand_id();
        end
        pool_id[1] = pool_id[0];

        // Directed part
        queue_cmd(CMD_TICK,   1'b0, '0, '0, '0);            // nothing held: no result
        queue_cmd(CMD_CANCEL, 1'b1, '1, '0, '0);            // empty table: not found
        queue_cmd(CMD_REQ,    1'b1, '1, '1, '0);            // all-ones id/signal, due now
        queue_cmd(CMD_REQ,    1'b0, '0, '0, '1);            // longest delay, lingers
        queue_cmd(CMD_REQ,    1'b0, 22'h155555, 7'd64, 16'd1);
        queue_cmd(CMD_CANCEL, 1'b1, '0, '0, '0);            // id matches, kind does not
        queue_cmd(CMD_REQ,    1'b0, 22'h2AAAAA, 7'd1, 16'd2);
        queue_cmd(CMD_REQ,    1'b0, 22'h2AAAAA, 7'd2, 16'd3);
        queue_cmd(CMD_CANCEL, 1'b0, 22'h2AAAAA, '0, '0);    // oldest of the pair goes
        queue_cmd(CMD_UNUSED, 1'b1, '1, '1, '1);            // dropped silently
        queue_cmd(CMD_TICK,   1'b0, '0, '0, '0);            // two fire, newest first
        queue_cmd(CMD_TICK,   1'b1, '1, '1, '1);            // tick ignores its fields
        queue_cmd(CMD_TICK,   1'b0, '0, '0, '0);
        queue_cmd(CMD_CANCEL, 1'b0, '0, '0, '0);            // clears the lingering one
        queue_cmd(CMD_REQ,    1'b1, 22'h2AAAAA, 7'd127, 16'h5555);
        queue_cmd(CMD_CANCEL, 1'b1, 22'h2AAAAA, '0, '0);

        // Random part: mostly pool traffic with short delays so alarms fire,
        // bursts that overfill the table, and some noise
        while (random_items < N_RANDOM) begin
            r = $urandom_range(99);
            if (r < 12) begin
                n = $urandom_range(1, TABLE_DEPTH + 3);
                for (int k = 0; k < n; k++) begin
                    sel = $urandom_range(OWNERS - 1);
                    queue_cmd(CMD_REQ, pool_thr[sel], pool_id[sel], rand_sig(),
                              DELAY_W'($urandom_range(0, 2)));
                    random_items++;
                end
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    queue_cmd(CMD_TICK, 1'b0, '0, '0, '0);
                    random_items++;
                end
            end else if (r < 18) begin
                sel = $urandom_range(3);
                case (sel)
                    0: queue_cmd(CMD_UNUSED, 1'($urandom_range(1)), rand_id(), rand_sig(),
                                 rand_delay());
                    1: queue_cmd(CMD_REQ, 1'($urandom_range(1)), rand_id(), rand_sig(),
                                 DELAY_W'($urandom_range(0, 3)));
                    2: queue_cmd(CMD_CANCEL, 1'($urandom_range(1)), rand_id(), rand_sig(),
                                 rand_delay());
                    default: queue_cmd(CMD_TICK, 1'($urandom_range(1)), rand_id(),
                                       rand_sig(), rand_delay());
                endcase
                if (sel != 0)
                    random_items++;
            end else if (r < 55) begin
                queue_cmd(CMD_TICK, 1'($urandom_range(1)), rand_id(), rand_sig(),
                          rand_delay());
                random_items++;
            end else if (r < 82) begin
                sel = $urandom_range(OWNERS - 1);
                if ($urandom_range(99) < 5)
                    dly = rand_delay();
                else
                    dly = DELAY_W'($urandom_range(0, 6));
                queue_cmd(CMD_REQ, pool_thr[sel], pool_id[sel], rand_sig(), dly);
                random_items++;
            end else begin
                sel = $urandom_range(OWNERS - 1);
                queue_cmd(CMD_CANCEL, pool_thr[sel], pool_id[sel], rand_sig(), rand_delay());
                random_items++;
            end
        end

        // Reset once, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every item transferred, every result in, then let a last tick finish
        while (alarm_cmds_q.size() != 0) @(posedge clk);
        while (alarm_outcomes_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
